/* hw/rtl/svf_pkg.sv */
// shared types, constants and helpers for the state variable filter
`default_nettype none

package svf_pkg;

    // field and arithmetic formats
    localparam int SAMPLE_WIDTH    = 16;
    localparam int SAMPLE_FRAC     = SAMPLE_WIDTH - 1;
    localparam int STATE_WIDTH     = 32;
    localparam int COEF_FRAC       = 16;
    localparam int GAIN_WIDTH      = 16;
    localparam int GAIN_FRAC       = 15;
    localparam int FREQ_WIDTH      = 17;
    localparam int COEF_WIDTH      = 18;
    localparam int MODE_WIDTH      = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 18;

    // sample to state alignment (sample has fewer fraction bits than the state)
    localparam int IN_SHIFT   = COEF_FRAC - SAMPLE_FRAC;
    localparam int Y_WIDTH    = STATE_WIDTH - IN_SHIFT;
    localparam int PROD_WIDTH = STATE_WIDTH + COEF_WIDTH + 1;
    localparam int PSH_WIDTH  = PROD_WIDTH - COEF_FRAC;
    localparam int SUM_WIDTH  = PSH_WIDTH + 1;
    localparam int FPROD_WIDTH = GAIN_WIDTH + FREQ_WIDTH;

    localparam logic [COEF_WIDTH-1:0] DAMP_RESET = COEF_WIDTH'(1 << COEF_FRAC);

    typedef logic signed [STATE_WIDTH-1:0] t_state_val;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MODE = 2'd0,
        CFG_FREQ = 2'd1,
        CFG_DAMP = 2'd2
    } t_cfg_index;

    // output selection codes
    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_LOW  = 2'd0,
        MODE_BAND = 2'd1,
        MODE_HIGH = 2'd2
    } t_mode;

    // operand pair of the shared multiplier
    typedef enum logic [1:0] {
        MUL_DAMP = 2'd0,
        MUL_HIGH = 2'd1,
        MUL_BAND = 2'd2
    } t_mul_sel;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_MUL_D = 3'd1,
        S_HIGH  = 3'd2,
        S_MUL_B = 3'd3,
        S_BAND  = 3'd4,
        S_MUL_L = 3'd5,
        S_LOW   = 3'd6,
        S_OUT   = 3'd7
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_high;
        logic     upd_band;
        logic     upd_low;
        logic     out_load;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* hw/rtl/state_variable_filter.sv */
// top level of the state variable filter
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_sample_in, i_cutoff_scale, i_restart
//  output    out        o_out_valid / i_out_ready   o_sample_out
//  config    in         i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
//  a new sample is taken only once the previous one has gone through every step:
//  three dependent multiplies share one multiplier, each followed by an add and
//  saturate step, then the output register load.
//  reset is synchronous, clears the integrators and returns the configuration
//  to lowpass, zero frequency coefficient and unit damping.
//  a stalled result holds the sequencer in its last step; the next sample can
//  be taken while an earlier result still waits in the output register.
`default_nettype none

module state_variable_filter (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_wr_en,
    input  wire logic [svf_pkg::CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  wire logic [svf_pkg::CFG_DATA_WIDTH-1:0]      i_cfg_data,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic signed [svf_pkg::SAMPLE_WIDTH-1:0] i_sample_in,
    input  wire logic [svf_pkg::GAIN_WIDTH-1:0]          i_cutoff_scale,
    input  wire logic                                    i_restart,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic signed [svf_pkg::SAMPLE_WIDTH-1:0]      o_sample_out
);
    import svf_pkg::*;

    t_dp_cmd cmd;

    // sequencer
    svf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    svf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_in    (i_sample_in),
        .i_cutoff_scale (i_cutoff_scale),
        .i_restart      (i_restart),
        .i_cmd          (cmd),
        .o_sample_out   (o_sample_out)
    );

endmodule

`default_nettype wire

/* hw/rtl/svf_ctrl.sv */
// controller state machine: sequences one sample through the shared multiplier
`default_nettype none

module svf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output svf_pkg::t_dp_cmd     o_cmd
);
    import svf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // state and output flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.mul_sel = MUL_DAMP;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_D;
                end
            end
            S_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DAMP;
                n_state       = S_HIGH;
            end
            S_HIGH: begin
                o_cmd.upd_high = 1'b1;
                n_state        = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HIGH;
                n_state       = S_BAND;
            end
            S_BAND: begin
                o_cmd.upd_band = 1'b1;
                n_state        = S_MUL_L;
            end
            S_MUL_L: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_BAND;
                n_state       = S_LOW;
            end
            S_LOW: begin
                o_cmd.upd_low = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // wait until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hw/rtl/svf_dp.sv */
// datapath: config registers, integrator states, shared multiplier, saturation
`default_nettype none

module svf_dp (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_cfg_wr_en,
    input  wire logic [svf_pkg::CFG_INDEX_WIDTH-1:0]         i_cfg_index,
    input  wire logic [svf_pkg::CFG_DATA_WIDTH-1:0]          i_cfg_data,
    input  wire logic signed [svf_pkg::SAMPLE_WIDTH-1:0]     i_sample_in,
    input  wire logic [svf_pkg::GAIN_WIDTH-1:0]              i_cutoff_scale,
    input  wire logic                                        i_restart,
    input  wire svf_pkg::t_dp_cmd                            i_cmd,
    output logic signed [svf_pkg::SAMPLE_WIDTH-1:0]          o_sample_out
);
    import svf_pkg::*;

    localparam t_state_val STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam t_state_val STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    localparam logic signed [Y_WIDTH-1:0] Y_MAX =
        Y_WIDTH'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam logic signed [Y_WIDTH-1:0] Y_MIN =
        Y_WIDTH'($signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}));

    // clamp a wide sum to the state range
    function automatic t_state_val sat_state(input logic signed [SUM_WIDTH-1:0] v);
        t_state_val res;
        if (v > SUM_WIDTH'(STATE_MAX)) begin
            res = STATE_MAX;
        end else if (v < SUM_WIDTH'(STATE_MIN)) begin
            res = STATE_MIN;
        end else begin
            res = v[STATE_WIDTH-1:0];
        end
        return res;
    endfunction

    logic [MODE_WIDTH-1:0]  r_mode;
    logic [FREQ_WIDTH-1:0]  r_freq;
    logic [COEF_WIDTH-1:0]  r_damp;
    logic [COEF_WIDTH-1:0]  r_f;
    t_state_val             r_x;
    t_state_val             r_low;
    t_state_val             r_band;
    t_state_val             r_high;
    logic signed [PROD_WIDTH-1:0]   r_prod;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic [FPROD_WIDTH-1:0]         f_prod;
    t_state_val                     mul_a;
    logic [COEF_WIDTH-1:0]          mul_c;
    logic signed [PROD_WIDTH-1:0]   mul_p;
    logic signed [PSH_WIDTH-1:0]    prod_sh;
    logic signed [SUM_WIDTH-1:0]    high_sum;
    logic signed [SUM_WIDTH-1:0]    band_sum;
    logic signed [SUM_WIDTH-1:0]    low_sum;
    t_state_val                     sel;
    logic signed [Y_WIDTH-1:0]      y;
    logic signed [SAMPLE_WIDTH-1:0] y_clamp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LOW;
            r_freq <= '0;
            r_damp <= DAMP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MODE: r_mode <= i_cfg_data[MODE_WIDTH-1:0];
                CFG_FREQ: r_freq <= i_cfg_data[FREQ_WIDTH-1:0];
                CFG_DAMP: r_damp <= i_cfg_data[COEF_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // effective frequency coefficient: gain times coefficient, Q.31 here, taken as Q.16 into r_f at load
    assign f_prod = FPROD_WIDTH'(i_cutoff_scale) * FPROD_WIDTH'(r_freq);

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_DAMP: begin
                mul_a = r_band;
                mul_c = r_damp;
            end
            MUL_HIGH: begin
                mul_a = r_high;
                mul_c = r_f;
            end
            MUL_BAND: begin
                mul_a = r_band;
                mul_c = r_f;
            end
            default: begin
                mul_a = r_band;
                mul_c = r_damp;
            end
        endcase
    end

    assign mul_p   = PROD_WIDTH'(mul_a) * PROD_WIDTH'($signed({1'b0, mul_c}));
    assign prod_sh = r_prod[PROD_WIDTH-1:COEF_FRAC];

    // integrator sums
    assign high_sum = SUM_WIDTH'(r_x) - SUM_WIDTH'(r_low) - SUM_WIDTH'(prod_sh);
    assign band_sum = SUM_WIDTH'(r_band) + SUM_WIDTH'(prod_sh);
    assign low_sum  = SUM_WIDTH'(r_low) + SUM_WIDTH'(prod_sh);

    // sample load, product register and state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_band <= '0;
        end else begin
            if (i_cmd.load && i_restart) begin
                r_low  <= '0;
                r_band <= '0;
            end
            if (i_cmd.upd_band) begin
                r_band <= sat_state(band_sum);
            end
            if (i_cmd.upd_low) begin
                r_low <= sat_state(low_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= t_state_val'(i_sample_in) <<< IN_SHIFT;
            r_f <= f_prod[GAIN_FRAC +: COEF_WIDTH];
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.upd_high) begin
            r_high <= sat_state(high_sum);
        end
        if (i_cmd.out_load) begin
            r_out <= y_clamp;
        end
    end

    // output select, format conversion and clamp
    always_comb begin
        case (r_mode)
            MODE_HIGH: sel = r_high;
            MODE_BAND: sel = r_band;
            default:   sel = r_low;
        endcase
        y = sel[STATE_WIDTH-1:IN_SHIFT];
        if (y > Y_MAX) begin
            y_clamp = Y_MAX[SAMPLE_WIDTH-1:0];
        end else if (y < Y_MIN) begin
            y_clamp = Y_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            y_clamp = y[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_sample_out = r_out;

endmodule

`default_nettype wire

/* hw/rtl/svf_checker.sv */
// port-level checks for the state variable filter, bound to the top level
`default_nettype none

module svf_checker (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    input  wire logic                                    o_in_ready,
    input  wire logic signed [svf_pkg::SAMPLE_WIDTH-1:0] i_sample_in,
    input  wire logic [svf_pkg::GAIN_WIDTH-1:0]          i_cutoff_scale,
    input  wire logic                                    i_restart,
    input  wire logic                                    o_out_valid,
    input  wire logic                                    i_out_ready,
    input  wire logic signed [svf_pkg::SAMPLE_WIDTH-1:0] o_sample_out
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one sample at a time: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an input transfer");

    // a result never appears in the cycle after an input transfer
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result too soon after input transfer");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled result changed or dropped");

    // waiting input holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_sample_in)
            && $stable(i_cutoff_scale) && $stable(i_restart))
        else $error("waiting input changed or dropped");

endmodule

bind state_variable_filter svf_checker u_svf_checker (.*);

`default_nettype wire
